### design/smet_pkg.sv
package smet_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef enum logic [3:0] {
    PhEvent,
    PhDelay1,
    PhDelay2,
    PhParam1,
    PhParam2,
    PhSingle,
    PhCount,
    PhCdata,
    PhSysex,
    PhMtype,
    PhMlen,
    PhMdata,
    PhDone
  } smet_phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       segment_start;
  } smet_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       segment_end;
    logic       last;
  } smet_out_t;

  typedef struct packed {
    smet_phase_e phase;
    logic [7:0]  running_status;
    logic        pending_zero_delay;
    logic [7:0]  bytes_left;
    logic [7:0]  held_note;
  } smet_state_t;

  // one decoded item: up to MaxResults result bytes plus their count
  typedef struct packed {
    smet_out_t [MaxResults-1:0] res;
    logic [CntW-1:0]            cnt;
  } smet_batch_t;

endpackage

### design/smet_decode.sv
module smet_decode (
  input  smet_pkg::smet_in_t    in_data_i,
  input  smet_pkg::smet_state_t state_i,
  input  logic                  drum_note_off_i,
  output smet_pkg::smet_state_t state_o,
  output smet_pkg::smet_batch_t batch_o
);

  localparam logic [7:0] SysexStart = 8'hF0;
  localparam logic [7:0] SysexCount = 8'hF7;
  localparam logic [7:0] MetaStatus = 8'hFF;
  localparam logic [7:0] MetaEnd    = 8'h2F;
  localparam logic [7:0] DrumNoteOn = 8'h99;
  localparam logic [7:0] DataMask   = 8'h7F;
  localparam logic [7:0] VelMax     = 8'h7F;
  localparam logic [3:0] ChanDrum   = 4'h9;
  localparam logic [3:0] ChanSwap   = 4'hF;
  localparam logic [3:0] HiNoteOff  = 4'h8;
  localparam logic [3:0] HiProgram  = 4'hC;
  localparam logic [3:0] HiPressure = 4'hD;
  localparam logic [3:0] HiSystem   = 4'hF;

  function automatic smet_pkg::smet_out_t mk(input logic [7:0] b, input logic v,
                                             input logic e);
    smet_pkg::smet_out_t r;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.segment_end = e;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic smet_pkg::smet_phase_e phase_for(input logic [7:0] s);
    smet_pkg::smet_phase_e p;
    if (s[7:4] == HiNoteOff || s[7:4] == HiProgram || s[7:4] == HiPressure) begin
      p = smet_pkg::PhSingle;
    end else if (s[7:4] == HiSystem) begin
      if (s == SysexStart)      p = smet_pkg::PhSysex;
      else if (s == SysexCount) p = smet_pkg::PhCount;
      else if (s == MetaStatus) p = smet_pkg::PhMtype;
      else                      p = smet_pkg::PhDone;
    end else begin
      p = smet_pkg::PhParam1;
    end
    return p;
  endfunction

  smet_pkg::smet_state_t cur;
  smet_pkg::smet_state_t nxt;
  smet_pkg::smet_phase_e ph;
  smet_pkg::smet_out_t   pre  [2];
  smet_pkg::smet_out_t   body [smet_pkg::MaxResults];
  logic [1:0]            pcnt;
  logic [smet_pkg::CntW-1:0] bcnt;
  logic [smet_pkg::CntW-1:0] total;
  logic                  run_body;
  logic [7:0]            b;
  logic [7:0]            s;
  logic [7:0]            bl_dec;

  assign b = in_data_i.in_byte;

  always_comb begin
    cur = state_i;
    if (in_data_i.segment_start) begin
      cur.phase              = smet_pkg::PhEvent;
      cur.running_status     = '0;
      cur.pending_zero_delay = 1'b0;
      cur.bytes_left         = '0;
      cur.held_note          = '0;
    end
  end

  always_comb begin
    nxt      = cur;
    pre[0]   = '0;
    pre[1]   = '0;
    pcnt     = '0;
    run_body = 1'b1;
    ph       = cur.phase;
    s        = b;
    if (cur.phase == smet_pkg::PhEvent) begin
      if (cur.pending_zero_delay) begin
        pre[0] = mk(8'h00, 1'b1, 1'b0);
        pcnt   = 2'd1;
        nxt.pending_zero_delay = 1'b0;
      end
      if (b[7]) begin
        // status byte: swap channels 9 and 15 on channel-voice messages
        if (b[7:4] != HiSystem) begin
          if (b[3:0] == ChanDrum)      s = {b[7:4], ChanSwap};
          else if (b[3:0] == ChanSwap) s = {b[7:4], ChanDrum};
        end
        nxt.running_status = s;
        ph        = phase_for(s);
        nxt.phase = ph;
        run_body  = 1'b0;
        if (s != MetaStatus) begin
          pre[pcnt[0]] = mk(s, 1'b1, ph == smet_pkg::PhDone);
          pcnt         = pcnt + 2'd1;
        end
      end else begin
        // running status; non-meta system status is re-emitted ahead of the data
        ph        = phase_for(cur.running_status);
        nxt.phase = ph;
        if (cur.running_status[7:4] == HiSystem && cur.running_status != MetaStatus) begin
          pre[pcnt[0]] = mk(cur.running_status, 1'b1, ph == smet_pkg::PhDone);
          pcnt         = pcnt + 2'd1;
          if (ph == smet_pkg::PhDone) run_body = 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_o = nxt;
    for (int i = 0; i < smet_pkg::MaxResults; i++) body[i] = '0;
    bcnt   = '0;
    bl_dec = cur.bytes_left - 8'd1;
    if (run_body) begin
      unique case (ph) inside
        smet_pkg::PhDelay1: begin
          body[0] = mk(b, 1'b1, 1'b0);
          bcnt    = 3'd1;
          state_o.phase = b[7] ? smet_pkg::PhDelay2 : smet_pkg::PhEvent;
        end
        smet_pkg::PhDelay2: begin
          body[0] = mk(b, 1'b1, 1'b0);
          bcnt    = 3'd1;
          state_o.phase = smet_pkg::PhEvent;
        end
        smet_pkg::PhParam1: begin
          body[0] = mk(b, 1'b1, 1'b0);
          bcnt    = 3'd1;
          state_o.held_note = b;
          state_o.phase     = smet_pkg::PhParam2;
        end
        smet_pkg::PhParam2, smet_pkg::PhSingle: begin
          body[0] = mk(b & DataMask, 1'b1, 1'b0);
          bcnt    = 3'd1;
          if (ph == smet_pkg::PhParam2) begin
            // drum note-off: delay 0, note, velocity 0
            if (cur.running_status == DrumNoteOn && drum_note_off_i) begin
              body[1] = mk(8'h00, 1'b1, 1'b0);
              body[2] = mk(cur.held_note, 1'b1, 1'b0);
              body[3] = mk(8'h00, 1'b1, 1'b0);
              bcnt    = 3'd4;
            end
          end else if (cur.running_status[7:4] == HiNoteOff) begin
            body[1] = mk(VelMax, 1'b1, 1'b0);
            bcnt    = 3'd2;
          end
          if (b[7]) begin
            state_o.pending_zero_delay = 1'b1;
            state_o.phase              = smet_pkg::PhEvent;
          end else begin
            state_o.phase = smet_pkg::PhDelay1;
          end
        end
        smet_pkg::PhCount, smet_pkg::PhMlen: begin
          body[0] = mk(b, 1'b1, 1'b0);
          bcnt    = 3'd1;
          state_o.bytes_left = b;
          if (b == 8'h00)                  state_o.phase = smet_pkg::PhDelay1;
          else if (ph == smet_pkg::PhCount) state_o.phase = smet_pkg::PhCdata;
          else                              state_o.phase = smet_pkg::PhMdata;
        end
        smet_pkg::PhCdata, smet_pkg::PhMdata: begin
          body[0] = mk(b, 1'b1, 1'b0);
          bcnt    = 3'd1;
          state_o.bytes_left = bl_dec;
          if (bl_dec == 8'h00) state_o.phase = smet_pkg::PhDelay1;
        end
        smet_pkg::PhSysex: begin
          body[0] = mk(b, 1'b1, 1'b0);
          bcnt    = 3'd1;
          // terminator doubles as a long first delay byte
          if (b == SysexCount) state_o.phase = smet_pkg::PhDelay2;
        end
        smet_pkg::PhMtype: begin
          if (b == MetaEnd) begin
            body[0] = mk(8'h00, 1'b0, 1'b1);
            bcnt    = 3'd1;
            state_o.phase = smet_pkg::PhDone;
          end else begin
            body[0] = mk(MetaStatus, 1'b1, 1'b0);
            body[1] = mk(b, 1'b1, 1'b0);
            bcnt    = 3'd2;
            state_o.phase = smet_pkg::PhMlen;
          end
        end
        default: begin
          state_o.phase = smet_pkg::PhDone;
        end
      endcase
    end
  end

  always_comb begin
    total = {1'b0, pcnt} + bcnt;
    for (int i = 0; i < smet_pkg::MaxResults; i++) begin
      if (2'(i) < pcnt && i < 2) begin
        batch_o.res[i] = pre[i[0]];
      end else begin
        batch_o.res[i] = body[2'(i) - pcnt];
      end
      batch_o.res[i].last = (3'(i) + 3'd1 == total);
    end
    batch_o.cnt = total;
  end

endmodule

### design/smet_outbuf.sv
module smet_outbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  smet_pkg::smet_batch_t batch_i,
  output logic                  can_load_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output smet_pkg::smet_out_t   out_data_o
);

  smet_pkg::smet_out_t       buf_q [smet_pkg::MaxResults];
  smet_pkg::smet_out_t       buf_d [smet_pkg::MaxResults];
  logic [smet_pkg::CntW-1:0] cnt_q;
  logic [smet_pkg::CntW-1:0] cnt_d;
  logic                      take;

  assign out_valid_o = (cnt_q != '0);
  assign take        = out_valid_o && out_ready_i;
  assign can_load_o  = (cnt_q == '0) || (cnt_q == 3'd1 && out_ready_i);
  assign out_data_o  = buf_q[0];

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load_i) begin
      for (int i = 0; i < smet_pkg::MaxResults; i++) buf_d[i] = batch_i.res[i];
      cnt_d = batch_i.cnt;
    end else if (take) begin
      // shift the queue towards the head
      for (int i = 0; i < smet_pkg::MaxResults - 1; i++) buf_d[i] = buf_q[i+1];
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(smet_pkg::MaxResults))
    else $error("result count over capacity");

  a_last_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'd1) |-> buf_q[0].last)
    else $error("final result of an item lacks last");

  a_no_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 3'd1) |-> !buf_q[0].last)
    else $error("last raised before the item's final result");

  a_load_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && cnt_q != '0) |-> (take && cnt_q == 3'd1))
    else $error("new item loaded over pending results");

endmodule

### design/sequence_to_midi_event_transcoder_top.sv
// Timing: the first result of an item is offered in the cycle after the item is taken.
// Throughput: one item per cycle while each item yields at most one result and the
//   output is ready; an item yielding more than one result (up to 4) holds the input
//   until the single output queue (one result per cycle while ready) holds its last one.
// Reset: asynchronous, active low; clears phase, running status and counters,
//   empties the output queue and sets drum_note_off to 1.
module sequence_to_midi_event_transcoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  smet_pkg::smet_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output smet_pkg::smet_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i
);

  smet_pkg::smet_state_t state_q;
  smet_pkg::smet_state_t state_d;
  smet_pkg::smet_batch_t batch;
  logic                  drum_q;
  logic                  in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  smet_decode u_decode (
    .in_data_i       (in_data_i),
    .state_i         (state_q),
    .drum_note_off_i (drum_q),
    .state_o         (state_d),
    .batch_o         (batch)
  );

  smet_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .batch_i     (batch),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase              <= smet_pkg::PhEvent;
      state_q.running_status     <= '0;
      state_q.pending_zero_delay <= 1'b0;
      state_q.bytes_left         <= '0;
      state_q.held_note          <= '0;
      drum_q                     <= 1'b1;
    end else begin
      if (in_fire) state_q <= state_d;
      if (cfg_we_i) drum_q <= cfg_data_i;
    end
  end

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q.phase == smet_pkg::PhDone && !in_data_i.segment_start)
      |=> !out_valid_o)
    else $error("item after segment end produced a result");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q.phase == smet_pkg::PhDone && !in_data_i.segment_start)
      |=> state_q.phase == smet_pkg::PhDone)
    else $error("segment reopened without segment_start");

endmodule
